FILE: rtl/tct_pkg.sv
`timescale 1ns / 1ps
package tct_pkg;

   // Display command codes
   localparam logic CMD_ADDR = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // Request kinds
   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_SET  = 1'b1;

   // Control characters
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Glyph geometry, small (8x6) and large (16x8) font
   localparam logic [7:0] COL_STEP_SMALL = 8'd6;
   localparam logic [7:0] COL_STEP_LARGE = 8'd8;
   localparam logic [1:0] ROW_STEP_SMALL = 2'd1;
   localparam logic [1:0] ROW_STEP_LARGE = 2'd2;
   localparam logic [7:0] COL_LIMIT_SMALL = 8'd122;
   localparam logic [7:0] COL_LIMIT_LARGE = 8'd119;
   localparam logic [7:0] LINE_END_SMALL  = 8'd126;
   localparam logic [7:0] LINE_END_LARGE  = 8'd120;

   // Result queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       req_type;
      logic [7:0] char_code;
      logic [2:0] new_row;
      logic [7:0] new_col;
   } tct_request_type;

   typedef struct packed {
      logic       command;
      logic [7:0] glyph;
      logic [2:0] page_row;
      logic [7:0] pixel_col;
      logic       last;
   } tct_result_type;

   typedef struct packed {
      logic [1:0]     num;
      tct_result_type first;
      tct_result_type second;
      logic [2:0]     row;
      logic [7:0]     col;
   } tct_step_type;

endpackage

FILE: rtl/tct_step.sv
`timescale 1ns / 1ps
module tct_step (
   input  tct_pkg::tct_request_type req,
   input  logic                     large_font,
   input  logic [2:0]               cur_row,
   input  logic [7:0]               cur_col,
   output tct_pkg::tct_step_type    step
);
   import tct_pkg::*;

   logic [1:0] row_step;
   logic [7:0] col_step;
   logic [7:0] col_limit;
   logic [7:0] line_end;
   logic [3:0] row_up;
   logic [2:0] row_wrapped;
   logic [2:0] back_row;
   logic [7:0] back_col;
   logic [7:0] fwd_col;
   logic       line_wrap;
   logic       page_wrap;

   assign row_step  = large_font ? ROW_STEP_LARGE  : ROW_STEP_SMALL;
   assign col_step  = large_font ? COL_STEP_LARGE  : COL_STEP_SMALL;
   assign col_limit = large_font ? COL_LIMIT_LARGE : COL_LIMIT_SMALL;
   assign line_end  = large_font ? LINE_END_LARGE  : LINE_END_SMALL;

   // row moved down; anything past the last page lands on the top page
   assign row_up      = {1'b0, cur_row} + {2'b00, row_step};
   assign row_wrapped = row_up[3] ? 3'd0 : row_up[2:0];

   assign back_row = (cur_col == 8'd0) ? (cur_row - {1'b0, row_step}) : cur_row;
   assign back_col = ((cur_col == 8'd0) ? line_end : cur_col) - col_step;

   assign fwd_col   = cur_col + col_step;
   assign line_wrap = fwd_col > col_limit;
   assign page_wrap = line_wrap && row_up[3];

   always_comb begin
      step.num    = 2'd0;
      step.first  = '0;
      step.second = '{command: CMD_ADDR, glyph: 8'd0, page_row: 3'd0,
                      pixel_col: 8'd0, last: 1'b1};
      step.row    = cur_row;
      step.col    = cur_col;
      if (req.req_type == REQ_SET) begin
         step.row = req.new_row;
         step.col = req.new_col;
      end else begin
         step.num = 2'd1;
         priority if (req.char_code == CH_CR) begin
            step.col   = 8'd0;
            step.first = '{command: CMD_ADDR, glyph: 8'd0, page_row: cur_row,
                           pixel_col: 8'd0, last: 1'b1};
         end else if (req.char_code == CH_LF) begin
            step.row   = row_wrapped;
            step.first = '{command: CMD_ADDR, glyph: 8'd0, page_row: row_wrapped,
                           pixel_col: cur_col, last: 1'b1};
         end else if (req.char_code == CH_BS || req.char_code == CH_DEL) begin
            step.row   = back_row;
            step.col   = back_col;
            step.first = '{command: CMD_DRAW, glyph: CH_SPACE, page_row: back_row,
                           pixel_col: back_col, last: 1'b1};
         end else begin
            step.row   = line_wrap ? row_wrapped : cur_row;
            step.col   = line_wrap ? 8'd0 : fwd_col;
            step.first = '{command: CMD_DRAW, glyph: req.char_code, page_row: cur_row,
                           pixel_col: cur_col, last: !page_wrap};
            if (page_wrap) begin
               step.num = 2'd2;
            end
         end
      end
   end

endmodule

FILE: rtl/tct_queue.sv
`timescale 1ns / 1ps
module tct_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_num,
   input  tct_pkg::tct_result_type push_a,
   input  tct_pkg::tct_result_type push_b,
   output logic                    room2,
   output logic                    out_valid,
   input  logic                    out_ready,
   output tct_pkg::tct_result_type out_data
);
   import tct_pkg::*;

   tct_result_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic [QUEUE_AW-1:0]   wr_ptr_nxt;
   logic                  pop;

   assign out_valid  = count_ff != '0;
   assign out_data   = mem_ff[rd_ptr_ff];
   assign room2      = count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2);
   assign pop        = out_valid && out_ready;
   assign wr_ptr_nxt = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push_num);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      count_in  = count_ff + QUEUE_CW'(push_num) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_a;
      end
      if (push_num == 2'd2) begin
         mem_ff[wr_ptr_nxt] <= push_b;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_num != 2'd0 |-> room2)
      else $error("result queue pushed without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("result queue count out of range");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push_num == 2'd0) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("result queue count did not drop on pop");

endmodule

FILE: rtl/text_cursor_tracker.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake             | Payload
// req_      | in        | req_valid / req_ready | type, char code, new row, new column
// rsp_      | out       | rsp_valid / rsp_ready | command, glyph, page row, column, last
// csr_      | in        | csr_write_en          | large font select
//
// One request per cycle. A request is held in the input register, then the cursor
// step logic updates the cursor and pushes 0, 1 or 2 results into a four-entry
// result queue, from whose head the first result shows on rsp_.
// A page wrap produces two results. Reset clears cursor, font and queue.
// Processing stalls only when the queue has fewer than two free entries.
module text_cursor_tracker (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [7:0] req_char_code,
   input  logic [2:0] req_new_row,
   input  logic [7:0] req_new_col,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_command,
   output logic [7:0] rsp_glyph,
   output logic [2:0] rsp_page_row,
   output logic [7:0] rsp_pixel_col,
   output logic       rsp_last,
   // configuration
   input  logic       csr_write_en,
   input  logic       csr_write_data
);
   import tct_pkg::*;

   // input register
   logic            in_valid_ff, in_valid_in;
   tct_request_type in_req_ff;

   // cursor state and font select
   logic [2:0]      row_ff, row_in;
   logic [7:0]      col_ff, col_in;
   logic            large_font_ff, large_font_in;

   tct_step_type    step;
   tct_result_type  rsp;
   logic            room2;
   logic            proc_fire;
   logic [1:0]      push_num;

   // a held request moves on once the queue can take a worst-case pair
   assign proc_fire = in_valid_ff && room2;
   assign req_ready = !in_valid_ff || proc_fire;
   assign push_num  = proc_fire ? step.num : 2'd0;

   always_comb begin
      in_valid_in   = in_valid_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      large_font_in = csr_write_en ? csr_write_data : large_font_ff;
      if (proc_fire) begin
         in_valid_in = 1'b0;
         row_in      = step.row;
         col_in      = step.col;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         row_ff        <= 3'd0;
         col_ff        <= 8'd0;
         large_font_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         large_font_ff <= large_font_in;
      end
   end

   // request payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= '{req_type: req_type, char_code: req_char_code,
                        new_row: req_new_row, new_col: req_new_col};
      end
   end

   tct_step u_step (
      .req        (in_req_ff),
      .large_font (large_font_ff),
      .cur_row    (row_ff),
      .cur_col    (col_ff),
      .step       (step)
   );

   tct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_num  (push_num),
      .push_a    (step.first),
      .push_b    (step.second),
      .room2     (room2),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp)
   );

   assign rsp_command   = rsp.command;
   assign rsp_glyph     = rsp.glyph;
   assign rsp_page_row  = rsp.page_row;
   assign rsp_pixel_col = rsp.pixel_col;
   assign rsp_last      = rsp.last;

   // a set request never produces a result
   a_set_silent: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && in_req_ff.req_type == REQ_SET) |-> push_num == 2'd0)
      else $error("set request produced a result");

   // a pair always ends on an address command to the top left
   a_pair_tail: assert property (@(posedge clock) disable iff (reset)
      push_num == 2'd2 |-> (step.second.command == CMD_ADDR && step.row == 3'd0
                            && step.col == 8'd0 && !step.first.last))
      else $error("page wrap pair malformed");

   // cursor only moves when a request is processed
   a_cursor_hold: assert property (@(posedge clock) disable iff (reset)
      !proc_fire |=> ($stable(row_ff) && $stable(col_ff)))
      else $error("cursor moved without a request");

endmodule

FILE: tb/text_cursor_tracker_tb.sv
`timescale 1ns / 1ps
// Console cursor tracker bench.
// A clocked driver sends character and set-cursor requests from a queue of
// scheduled operations. A clocked monitor keeps its own copy of the cursor and
// font, works out the display commands that each accepted request should
// cause, and checks every result against the oldest outstanding command.
module text_cursor_tracker_tb;
   import tct_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 6;    // set requests leave no result behind
   localparam int unsigned END_SETTLE    = 8;
   localparam int unsigned HOLD_CYCLES   = 60;   // long receiver back-off
   localparam int unsigned STALL_LIMIT   = 2000; // cycles with no handshake at all
   localparam int unsigned SEG_ITEMS     = 80;

   // Operations scheduled for the driver
   typedef enum {OP_REQUEST, OP_FONT, OP_DRAIN, OP_HOLD, OP_IDLING} console_op_kind_type;

   typedef struct {
      console_op_kind_type kind;
      tct_request_type     req;
      int unsigned         arg_a;   // font bit, or sender idle percentage
      int unsigned         arg_b;   // receiver idle percentage
   } console_op_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_type = REQ_CHAR;
   logic [7:0] req_char_code = '0;
   logic [2:0] req_new_row = '0;
   logic [7:0] req_new_col = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_command;
   logic [7:0] rsp_glyph;
   logic [2:0] rsp_page_row;
   logic [7:0] rsp_pixel_col;
   logic       rsp_last;
   logic       csr_write_en = 1'b0;
   logic       csr_write_data = 1'b0;

   console_op_type char_stream[$];    // filled up front, drained by the driver
   tct_result_type pending_cmds[$];   // display commands still to come

   // Monitor's view of the block
   logic        font_shadow;
   logic [2:0]  cursor_row_q;
   logic [7:0]  cursor_col_q;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;

   // Driver-owned knobs, read by the receiver and the main sequence
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_req = 0;
   logic        stim_done = 1'b0;

   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned stall_cycles = 0;

   text_cursor_tracker dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_new_row    (req_new_row),
      .req_new_col    (req_new_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_command    (rsp_command),
      .rsp_glyph      (rsp_glyph),
      .rsp_page_row   (rsp_page_row),
      .rsp_pixel_col  (rsp_pixel_col),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Scheduling helpers
   // ---------------------------------------------------------------
   task automatic queue_request(input logic rtype, input logic [7:0] code,
                                input logic [2:0] row, input logic [7:0] col);
      console_op_type op;
      op.kind          = OP_REQUEST;
      op.req.req_type  = rtype;
      op.req.char_code = code;
      op.req.new_row   = row;
      op.req.new_col   = col;
      op.arg_a         = 0;
      op.arg_b         = 0;
      char_stream.push_back(op);
   endtask

   // Unused fields carry random junk so that the block is seen to ignore them
   task automatic queue_char(input logic [7:0] code);
      queue_request(REQ_CHAR, code, 3'($urandom_range(7)), 8'($urandom_range(255)));
   endtask

   task automatic queue_set(input logic [2:0] row, input logic [7:0] col);
      queue_request(REQ_SET, 8'($urandom_range(255)), row, col);
   endtask

   task automatic queue_control(input console_op_kind_type kind, input int unsigned a,
                                input int unsigned b);
      console_op_type op;
      op.kind  = kind;
      op.req   = '0;
      op.arg_a = a;
      op.arg_b = b;
      char_stream.push_back(op);
   endtask

   // Mix weighted towards control codes and cursor moves near the line end,
   // so that line and page wraps come up often
   task automatic queue_random_request();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 14)
         queue_set(3'($urandom_range(7)),
                   $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(127, 100)));
      else if (pick < 24)
         queue_char(CH_CR);
      else if (pick < 34)
         queue_char(CH_LF);
      else if (pick < 40)
         queue_char(CH_BS);
      else if (pick < 46)
         queue_char(CH_DEL);
      else
         queue_char(8'($urandom_range(255)));
   endtask

   // ---------------------------------------------------------------
   // Cursor predictor: moves the shadow cursor and queues the commands
   // ---------------------------------------------------------------
   task automatic push_cmd(input logic cmd, input logic [7:0] glyph,
                           input logic [2:0] row, input logic [7:0] col, input logic fin);
      tct_result_type r;
      r.command   = cmd;
      r.glyph     = glyph;
      r.page_row  = row;
      r.pixel_col = col;
      r.last      = fin;
      pending_cmds.push_back(r);
   endtask

   task automatic advance_cursor(input tct_request_type rq);
      logic [1:0] row_step;
      logic [7:0] col_step, col_limit;
      logic [3:0] row_sum;
      logic [2:0] draw_row;
      logic [7:0] draw_col;
      logic       page_wrap;
      row_step  = font_shadow ? ROW_STEP_LARGE : ROW_STEP_SMALL;
      col_step  = font_shadow ? COL_STEP_LARGE : COL_STEP_SMALL;
      col_limit = font_shadow ? COL_LIMIT_LARGE : COL_LIMIT_SMALL;
      if (rq.req_type == REQ_SET) begin
         cursor_row_q = rq.new_row;
         cursor_col_q = rq.new_col;
      end else if (rq.char_code == CH_CR) begin
         cursor_col_q = '0;
         push_cmd(CMD_ADDR, '0, cursor_row_q, '0, 1'b1);
      end else if (rq.char_code == CH_LF) begin
         row_sum      = {1'b0, cursor_row_q} + {2'b00, row_step};
         cursor_row_q = (row_sum >= 4'd8) ? 3'd0 : row_sum[2:0];
         push_cmd(CMD_ADDR, '0, cursor_row_q, cursor_col_q, 1'b1);
      end else if (rq.char_code == CH_BS || rq.char_code == CH_DEL) begin
         // from column 0, back to the end of the previous line (row wraps mod 8)
         if (cursor_col_q == '0) begin
            cursor_row_q = cursor_row_q - {1'b0, row_step};
            cursor_col_q = font_shadow ? LINE_END_LARGE : LINE_END_SMALL;
         end
         cursor_col_q = cursor_col_q - col_step;
         push_cmd(CMD_DRAW, CH_SPACE, cursor_row_q, cursor_col_q, 1'b1);
      end else begin
         draw_row     = cursor_row_q;
         draw_col     = cursor_col_q;
         page_wrap    = 1'b0;
         cursor_col_q = cursor_col_q + col_step;   // wraps mod 256, may land below limit
         if (cursor_col_q > col_limit) begin
            cursor_col_q = '0;
            row_sum      = {1'b0, cursor_row_q} + {2'b00, row_step};
            if (row_sum >= 4'd8) begin
               cursor_row_q = '0;
               page_wrap    = 1'b1;
            end else begin
               cursor_row_q = row_sum[2:0];
            end
         end
         push_cmd(CMD_DRAW, rq.char_code, draw_row, draw_col, !page_wrap);
         if (page_wrap)
            push_cmd(CMD_ADDR, '0, 3'd0, 8'd0, 1'b1);
      end
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // ---------------------------------------------------------------
   // Monitor: tracks config writes, predicts on each accepted request,
   // checks each accepted result. Request side is handled first so the
   // order within the edge is fixed.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch_console
      tct_request_type rq;
      tct_result_type  want;
      if (reset) begin
         font_shadow  = 1'b0;
         cursor_row_q = '0;
         cursor_col_q = '0;
         pending_cmds.delete();
         quiet_cycles <= 0;
      end else begin
         if (csr_write_en)
            font_shadow = csr_write_data;
         if (req_valid && req_ready) begin
            rq.req_type  = req_type;
            rq.char_code = req_char_code;
            rq.new_row   = req_new_row;
            rq.new_col   = req_new_col;
            advance_cursor(rq);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_cmds.size() == 0) begin
               mismatches++;
               $display({"%0t ns: result with none expected, actual cmd %0d glyph %0d",
                         " row %0d col %0d last %0d"},
                        $time, rsp_command, rsp_glyph, rsp_page_row, rsp_pixel_col, rsp_last);
            end else begin
               want = pending_cmds.pop_front();
               check_field("command",   want.command,   rsp_command);
               check_field("glyph",     want.glyph,     rsp_glyph);
               check_field("page_row",  want.page_row,  rsp_page_row);
               check_field("pixel_col", want.pixel_col, rsp_pixel_col);
               check_field("last",      want.last,      rsp_last);
            end
         end
         // quiet = nothing on offer, nothing shown, nothing outstanding
         if (req_valid || rsp_valid || pending_cmds.size() != 0)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Driver: one operation at a time off char_stream. Font writes and
   // drain points wait for the block to go quiet.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      logic           nv_valid;
      logic           nv_wen;
      logic           take;
      console_op_type head;
      if (reset) begin
         req_valid    <= 1'b0;
         csr_write_en <= 1'b0;
      end else begin
         nv_valid = req_valid && !req_ready;   // hold until accepted
         nv_wen   = 1'b0;
         take     = 1'b0;
         if (!nv_valid && char_stream.size() != 0) begin
            head = char_stream[0];
            case (head.kind)
               OP_REQUEST: begin
                  if ($urandom_range(99) >= send_idle_pct) begin
                     take          = 1'b1;
                     nv_valid      = 1'b1;
                     req_type      <= head.req.req_type;
                     req_char_code <= head.req.char_code;
                     req_new_row   <= head.req.new_row;
                     req_new_col   <= head.req.new_col;
                  end
               end
               OP_FONT: begin
                  if (!req_valid && quiet_cycles >= SETTLE_CYCLES) begin
                     take           = 1'b1;
                     nv_wen         = 1'b1;
                     csr_write_data <= head.arg_a[0];
                  end
               end
               OP_DRAIN: begin
                  if (!req_valid && quiet_cycles >= SETTLE_CYCLES)
                     take = 1'b1;
               end
               OP_HOLD: begin
                  take     = 1'b1;
                  hold_req <= hold_req + 1;
               end
               OP_IDLING: begin
                  take          = 1'b1;
                  send_idle_pct <= head.arg_a;
                  recv_idle_pct <= head.arg_b;
               end
               default: take = 1'b1;
            endcase
            if (take)
               void'(char_stream.pop_front());
         end
         req_valid    <= nv_valid;
         csr_write_en <= nv_wen;
         if (!nv_valid && char_stream.size() == 0)
            stim_done <= 1'b1;
      end
   end

   // Receiver: random back-pressure, plus long hold-offs on request
   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: too long without any handshake means the block has hung
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Schedule and run
   // ---------------------------------------------------------------
   initial begin : run_sequence
      int unsigned seg;
      int unsigned n;

      queue_control(OP_IDLING, 19, 75);

      // small font, reset state: extremes and every control code
      queue_set(3'd7, 8'd255);
      queue_char(8'h00);            // drawn at column 255, column wraps to 5, no line wrap
      queue_char(8'hFF);
      queue_char(CH_CR);
      queue_char(CH_LF);            // row 7 to 0
      queue_char(CH_BS);            // column 0: back to previous line end, row 0 to 7
      queue_char(CH_DEL);
      queue_set(3'd7, 8'd120);
      queue_char(8'h5A);            // line wrap off the last row: page wrap, two results
      queue_set(3'd3, 8'd3);
      queue_char(CH_BS);            // column underflows mod 256
      queue_set(3'd0, 8'd0);
      queue_char(CH_LF);
      queue_char(CH_CR);

      // large font
      queue_control(OP_FONT, 1, 0);
      queue_set(3'd1, 8'd0);
      queue_char(CH_BS);            // odd row steps back by two: row 7
      queue_set(3'd6, 8'd112);
      queue_char(8'h41);            // page wrap in large font
      queue_set(3'd7, 8'd0);
      queue_char(CH_LF);            // 7 + 2 wraps to 0
      queue_set(3'd7, 8'd255);
      queue_char(8'h41);
      queue_char(CH_DEL);
      queue_char(CH_CR);

      // random segments: fonts alternate, idling changes every two segments
      for (seg = 0; seg < 6; seg++) begin
         if (seg == 2)
            queue_control(OP_IDLING, 75, 19);
         else if (seg == 4)
            queue_control(OP_IDLING, 0, 0);
         queue_control(OP_FONT, seg % 2, 0);
         if (seg == 1 || seg == 4)
            queue_control(OP_HOLD, 0, 0);   // sender keeps offering while rsp_ready is held low
         for (n = 0; n < SEG_ITEMS; n++) begin
            if (n == SEG_ITEMS / 2)
               queue_control(OP_DRAIN, 0, 0);
            queue_random_request();
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (!(stim_done && quiet_cycles >= END_SETTLE))
         @(posedge clock);

      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
